// ----- sv/htw_pkg.sv -----
// Package for the hashed timing wheel: payload structs, result kinds and
// default sizes. No dependencies.
package htw_pkg;

	localparam int WheelSlots   = 9;
	localparam int SlotCapacity = 16;
	localparam int DelayBits    = 16;

	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_DROPPED  = 2'd1;
	localparam logic [1:0] KIND_FIRED    = 2'd2;
	localparam logic [1:0] KIND_TICK_END = 2'd3;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	typedef struct packed {
		logic               func;
		logic [31:0]        handle;
		logic [7:0]         msg_type;
		logic signed [31:0] session;
		logic [15:0]        delay;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [31:0]        out_handle;
		logic [7:0]         out_type;
		logic signed [31:0] out_session;
		logic               last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;   // capture the accepted input item
		logic ins_start;   // start the slot and rounds computation
		logic ins_write;   // write the new entry, bump the fill count
		logic tick_start;  // advance the position, start the slot walk
		logic walk_read;   // issue the read of the next entry
		logic walk_step;   // consume the entry whose read data is ready
		logic walk_done;   // store the new fill count
		logic emit_ins;    // present the insert result
		logic emit_fire;   // present a fired timer
		logic emit_end;    // present the tick-end marker
	} htw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic func;
		logic div_done;
		logic walk_more;    // entries remain to be read
		logic fire;         // entry in hand has zero rounds
	} htw_sts_t;

endpackage

// ----- sv/htw_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
module htw_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/htw_datapath.sv -----
// Datapath of the hashed timing wheel: position, fill counts, entry RAM,
// reciprocal-multiply division for the slot and rounds. Depends on htw_pkg and htw_ram.
module htw_datapath
	import htw_pkg::*;
#(
	parameter int WheelSlots   = htw_pkg::WheelSlots,
	parameter int SlotCapacity = htw_pkg::SlotCapacity,
	parameter int DelayBits    = htw_pkg::DelayBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  htw_cmd_t  cmd,
	output htw_sts_t  sts,
	output out_item_t res
);

	localparam int SlotW  = $clog2(WheelSlots);
	localparam int CapW   = (SlotCapacity > 1) ? $clog2(SlotCapacity) : 1;
	localparam int FillW  = $clog2(SlotCapacity + 1);
	localparam int Depth  = WheelSlots * SlotCapacity;
	localparam int AddrW  = $clog2(Depth);
	localparam int DW     = (DelayBits < 16) ? DelayBits : 16;
	localparam int EntW   = 32 + 32 + 8 + DW;
	localparam logic [SlotW-1:0] LastSlot = SlotW'(WheelSlots - 1);

	// Reciprocal of the slot count, rounded up; exact for any DW-bit delay.
	localparam int Shift  = DW + SlotW;
	localparam int ProdW  = 2 * DW + 1;
	localparam logic [63:0] RecipL =
		((64'd1 << Shift) + 64'(WheelSlots) - 64'd1) / 64'(WheelSlots);
	localparam logic [DW:0] Recip = RecipL[DW:0];

	typedef struct packed {
		logic [31:0]        handle;
		logic signed [31:0] session;
		logic [7:0]         msg_type;
		logic [DW-1:0]      rounds;
	} entry_t;

	in_item_t          item_q;
	logic [SlotW-1:0]  pos_q;
	logic [FillW-1:0]  fill_q [WheelSlots];
	logic              full_q;

	// Division by the slot count in three steps: quotient by reciprocal
	// multiplication, then the remainder, then the slot from remainder
	// plus position.
	logic [DW-1:0]     quo_q;
	logic [SlotW-1:0]  rem_q;
	logic [1:0]        cnt_q;
	logic              busy_q;
	logic [SlotW-1:0]  slot_q;
	logic [DW-1:0]     rounds_q;

	// Walk state.
	logic [FillW-1:0]  rd_idx_q;
	logic [FillW-1:0]  keep_q;
	logic [FillW-1:0]  nfill_q;
	logic [AddrW-1:0]  rd_addr_q;

	logic              we;
	logic [AddrW-1:0]  waddr, raddr;
	entry_t            wdata, rdata;
	logic [ProdW-1:0]  prod;
	logic [DW-1:0]     qn;
	logic [DW-1:0]     rem_full;
	logic [SlotW:0]    slot_sum;
	logic [FillW-1:0]  cur_fill;

	assign cur_fill = fill_q[slot_q];
	assign prod     = ProdW'(item_q.delay[DW-1:0]) * ProdW'(Recip);
	assign qn       = quo_q * DW'(WheelSlots);
	assign rem_full = item_q.delay[DW-1:0] - qn;
	assign slot_sum = {1'b0, rem_q} + {1'b0, pos_q};

	function automatic logic [AddrW-1:0] addr_of(input logic [SlotW-1:0] s,
			input logic [FillW-1:0] k);
		addr_of = AddrW'(s) * AddrW'(SlotCapacity) + AddrW'(k[CapW-1:0]);
	endfunction

	// Divider busy flag and position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (cmd.ins_start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 2'd1) begin
				busy_q <= 1'b0;
			end
			if (cmd.tick_start) begin
				pos_q <= (pos_q == LastSlot) ? '0 : pos_q + 1'b1;
			end
		end
	end

	// Item capture, quotient, remainder and slot.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_item;
		end
		if (cmd.ins_start) begin
			quo_q <= DW'(prod >> Shift);
			cnt_q <= 2'd2;
		end else if (busy_q) begin
			rem_q <= SlotW'(rem_full);
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.tick_start) begin
			slot_q <= (pos_q == LastSlot) ? '0 : pos_q + 1'b1;
		end else if (busy_q && cnt_q == 2'd1) begin
			// Remainder plus position, wrapped once, is the slot.
			slot_q <= (slot_sum >= (SlotW+1)'(WheelSlots)) ?
				SlotW'(slot_sum - (SlotW+1)'(WheelSlots)) : SlotW'(slot_sum);
		end
	end

	// Rounds are the quotient of the delay; full flag of the target slot.
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			rounds_q <= quo_q;
			full_q   <= (cur_fill >= FillW'(SlotCapacity));
		end
	end

	// Fill counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WheelSlots; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cmd.ins_write && !full_q) begin
			fill_q[slot_q] <= cur_fill + 1'b1;
		end else if (cmd.walk_done) begin
			fill_q[slot_q] <= keep_q;
		end
	end

	// Walk counters.
	always_ff @(posedge clk) begin
		if (cmd.tick_start) begin
			rd_idx_q <= '0;
			keep_q   <= '0;
		end else begin
			if (cmd.walk_read) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.walk_step && rdata.rounds != '0) begin
				keep_q <= keep_q + 1'b1;
			end
		end
		if (cmd.walk_read && rd_idx_q == '0) begin
			nfill_q <= cur_fill;
		end
		if (cmd.walk_read) begin
			rd_addr_q <= raddr;
		end
	end

	// Entry RAM port selection: walk compaction or insert. The read address
	// holds between reads so the entry in hand stays put while the output waits.
	always_comb begin
		raddr = cmd.walk_read ? addr_of(slot_q, rd_idx_q) : rd_addr_q;
		if (cmd.walk_step) begin
			we    = (rdata.rounds != '0);
			waddr = addr_of(slot_q, keep_q);
			wdata = rdata;
			wdata.rounds = rdata.rounds - 1'b1;
		end else begin
			we    = cmd.ins_write && !full_q;
			waddr = addr_of(slot_q, cur_fill);
			wdata.handle   = item_q.handle;
			wdata.session  = item_q.session;
			wdata.msg_type = item_q.msg_type;
			wdata.rounds   = rounds_q;
		end
	end

	htw_ram #(.Width(EntW), .Depth(Depth)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Status to the controller.
	assign sts.func      = item_q.func;
	assign sts.div_done  = !busy_q;
	assign sts.walk_more = (rd_idx_q < ((rd_idx_q == '0) ? cur_fill : nfill_q));
	assign sts.fire      = (rdata.rounds == '0);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit_ins) begin
			res.kind        <= full_q ? KIND_DROPPED : KIND_ACCEPTED;
			res.out_handle  <= item_q.handle;
			res.out_type    <= item_q.msg_type;
			res.out_session <= item_q.session;
			res.last        <= 1'b1;
		end else if (cmd.emit_fire) begin
			res.kind        <= KIND_FIRED;
			res.out_handle  <= rdata.handle;
			res.out_type    <= rdata.msg_type;
			res.out_session <= rdata.session;
			res.last        <= 1'b0;
		end else if (cmd.emit_end) begin
			res.kind        <= KIND_TICK_END;
			res.out_handle  <= '0;
			res.out_type    <= '0;
			res.out_session <= '0;
			res.last        <= 1'b1;
		end
	end

endmodule

// ----- sv/htw_ctrl.sv -----
// Controller of the hashed timing wheel: sequences inserts and slot walks.
// Depends on htw_pkg.
module htw_ctrl
	import htw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  htw_sts_t sts,
	output htw_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DEC   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_INS   = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_STEP  = 3'd5;
	localparam logic [2:0] ST_WAIT  = 3'd6;
	localparam logic [2:0] ST_END   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       ovalid_q, ovalid_d;
	logic       out_free;

	// Output register is free when empty or being taken this cycle.
	assign out_free  = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign in_ready  = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		ovalid_d = ovalid_q && !out_ready;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (sts.func == FUNC_TICK) begin
					cmd.tick_start = 1'b1;
					state_d = ST_READ;
				end else begin
					cmd.ins_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				// Rounds and full settle while this state sees the divider done.
				if (sts.div_done) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				if (out_free) begin
					cmd.ins_write = 1'b1;
					cmd.emit_ins  = 1'b1;
					ovalid_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				if (sts.walk_more) begin
					cmd.walk_read = 1'b1;
					state_d = ST_STEP;
				end else begin
					state_d = ST_END;
				end
			end
			ST_STEP: begin
				if (!sts.fire) begin
					cmd.walk_step = 1'b1;
					state_d = ST_READ;
				end else if (out_free) begin
					cmd.walk_step = 1'b1;
					cmd.emit_fire = 1'b1;
					ovalid_d = 1'b1;
					state_d  = ST_READ;
				end else begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					cmd.walk_step = 1'b1;
					cmd.emit_fire = 1'b1;
					ovalid_d = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_END: begin
				if (out_free) begin
					cmd.walk_done = 1'b1;
					cmd.emit_end  = 1'b1;
					ovalid_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= ovalid_d;
		end
	end

endmodule

// ----- sv/hashed_timing_wheel_core.sv -----
// Hashed timing wheel: an insert computes the quotient by reciprocal
// multiplication, the remainder and the slot, registering each in turn before the
// entry is written, and a tick walks the slot through the single entry RAM,
// reading each entry and rewriting only those that are kept. One item
// is handled at a time; a finished result sits in an output register until
// taken, and a stalled output holds the wheel. Depends on htw_pkg,
// htw_ctrl and htw_datapath.
module hashed_timing_wheel_core
	import htw_pkg::*;
#(
	parameter int WheelSlots   = htw_pkg::WheelSlots,
	parameter int SlotCapacity = htw_pkg::SlotCapacity,
	parameter int DelayBits    = htw_pkg::DelayBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	htw_cmd_t cmd;
	htw_sts_t sts;

	htw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	htw_datapath #(
		.WheelSlots   (WheelSlots),
		.SlotCapacity (SlotCapacity),
		.DelayBits    (DelayBits)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_data),
		.cmd     (cmd),
		.sts     (sts),
		.res     (out_data)
	);

endmodule

// ----- bench/hashed_timing_wheel_core_tb.sv -----
// Testbench for hashed_timing_wheel_core: drives inserts and ticks over a
// valid/ready channel and checks every result against a built-in wheel model.
// Depends on htw_pkg and the hashed_timing_wheel_core RTL.
`timescale 1ns / 100ps

module hashed_timing_wheel_core_tb;
	import htw_pkg::*;

	localparam int NSLOT = WheelSlots;
	localparam int NCAP  = SlotCapacity;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	hashed_timing_wheel_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #4 clk = ~clk;

	// Wheel model state.
	int unsigned wheel_pos;
	int unsigned fill [NSLOT];
	logic [31:0] ent_handle [NSLOT][NCAP];
	logic [31:0] ent_session [NSLOT][NCAP];
	logic [7:0]  ent_type [NSLOT][NCAP];
	int unsigned ent_rounds [NSLOT][NCAP];

	out_item_t pending_results [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Append one expected result.
	task automatic queue_result(input out_item_t r);
		begin
			pending_results = {pending_results, r};
		end
	endtask

	// Compute the results one item causes and update the wheel model.
	task automatic predict_wheel(input in_item_t it);
		int unsigned slot, keep, d;
		out_item_t r;
		begin
			d = 32'(it.delay);
			if (it.func == FUNC_INSERT) begin
				slot = (d + wheel_pos) % NSLOT;
				r.out_handle = it.handle;
				r.out_type = it.msg_type;
				r.out_session = it.session;
				r.last = 1'b1;
				if (fill[slot] >= NCAP) begin
					r.kind = KIND_DROPPED;
				end else begin
					ent_handle[slot][fill[slot]] = it.handle;
					ent_type[slot][fill[slot]] = it.msg_type;
					ent_session[slot][fill[slot]] = it.session;
					ent_rounds[slot][fill[slot]] = d / NSLOT;
					fill[slot]++;
					r.kind = KIND_ACCEPTED;
				end
				queue_result(r);
			end else begin
				wheel_pos = (wheel_pos + 1) % NSLOT;
				slot = wheel_pos;
				keep = 0;
				for (int i = 0; i < fill[slot]; i++) begin
					if (ent_rounds[slot][i] == 0) begin
						r.kind = KIND_FIRED;
						r.out_handle = ent_handle[slot][i];
						r.out_type = ent_type[slot][i];
						r.out_session = ent_session[slot][i];
						r.last = 1'b0;
						queue_result(r);
					end else begin
						ent_handle[slot][keep] = ent_handle[slot][i];
						ent_type[slot][keep] = ent_type[slot][i];
						ent_session[slot][keep] = ent_session[slot][i];
						ent_rounds[slot][keep] = ent_rounds[slot][i] - 1;
						keep++;
					end
				end
				fill[slot] = keep;
				r = '0;
				r.kind = KIND_TICK_END;
				r.last = 1'b1;
				queue_result(r);
			end
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		begin
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			errors++;
		end
	endtask

	// Send one item, holding valid until the transfer. Valid is dropped only
	// while idling, so back-to-back items keep it high.
	task automatic send_item(input in_item_t it);
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_data <= it;
			in_valid <= 1'b1;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			predict_wheel(it);
			@(negedge clk);
		end
	endtask

	function automatic in_item_t make_insert(input logic [31:0] h, input logic [7:0] t,
			input logic [31:0] s, input logic [15:0] d);
		in_item_t it;
		begin
			it.func = FUNC_INSERT;
			it.handle = h;
			it.msg_type = t;
			it.session = s;
			it.delay = d;
			return it;
		end
	endfunction

	function automatic in_item_t make_tick();
		in_item_t it;
		begin
			it = '0;
			it.func = FUNC_TICK;
			it.handle = $urandom;
			it.session = $urandom;
			it.delay = 16'($urandom);
			it.msg_type = 8'($urandom);
			return it;
		end
	endfunction

	function automatic in_item_t rand_insert(input int unsigned dmax);
		return make_insert($urandom, 8'($urandom), $urandom, 16'($urandom_range(dmax)));
	endfunction

	// Receiver: random stalls, check each transfer against the oldest expectation.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", out_data.kind, 0);
			end else begin
				out_item_t w;
				w = pending_results.pop_front();
				if (out_data.kind !== w.kind) report("kind", out_data.kind, w.kind);
				if (out_data.out_handle !== w.out_handle)
					report("handle", out_data.out_handle, w.out_handle);
				if (out_data.out_type !== w.out_type)
					report("type", out_data.out_type, w.out_type);
				if (out_data.out_session !== w.out_session)
					report("session", out_data.out_session, w.out_session);
				if (out_data.last !== w.last) report("last", out_data.last, w.last);
			end
		end
	end

	// Stop sending and wait until every expected result has arrived.
	task automatic wait_drained();
		begin
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(negedge clk);
		end
	endtask

	// Extremes of every field, zero delay, and a whole wheel turn.
	task automatic test_directed();
		begin
			send_item(make_insert(32'hffff_ffff, 8'hff, 32'h7fff_ffff, 16'hffff));
			send_item(make_insert(32'h0, 8'h0, 32'h8000_0000, 16'h0));
			send_item(make_insert(32'h1234_5678, 8'h5a, 32'hffff_ffff, 16'd1));
			send_item(make_insert(32'h8765_4321, 8'ha5, 32'h0, 16'd9));
			send_item(make_insert(32'h5555_aaaa, 8'h3c, 32'h1, 16'd10));
			for (int i = 0; i < 12; i++)
				send_item(make_tick());
			// Pause until every result has come back.
			wait_drained();
		end
	endtask

	// Overfill one slot so that inserts are dropped, then drain it.
	task automatic test_slot_full();
		begin
			for (int i = 0; i < NCAP + 2; i++)
				send_item(make_insert($urandom, 8'($urandom), $urandom,
					(i % 3 == 0) ? 16'd2 : 16'd11));
			for (int i = 0; i < 2 * NSLOT + 2; i++)
				send_item(make_tick());
		end
	endtask

	// Random mix, mostly short delays so timers fire within the run.
	task automatic test_random(input int n);
		begin
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(2) == 0)
					send_item(make_tick());
				else if ($urandom_range(9) == 0)
					send_item(rand_insert(16'hffff));
				else
					send_item(rand_insert(3 * NSLOT));
			end
		end
	endtask

	initial begin
		wheel_pos = 0;
		foreach (fill[i]) fill[i] = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_slot_full();
		test_random(16);
		send_idle_pct = 58;
		test_random(16);
		send_idle_pct = 0;
		recv_stall_pct = 58;
		test_random(16);
		send_idle_pct = 16;
		recv_stall_pct = 16;
		test_random(16);
		wait_drained();
		repeat (100) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("hashed_timing_wheel_core_tb OK");
		else
			$display("hashed_timing_wheel_core_tb NOT OK");
		$finish;
	end

	initial begin
		#4ms;
		$display("hashed_timing_wheel_core_tb NOT OK");
		$finish;
	end

endmodule
